FILE: design/cau_pkg.sv
`default_nettype none

package cau_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int QDEPTH    = 4;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int WIDE_W    = 2 * DATA_W + 1;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [WIDE_W-1:0] t_wide;

    typedef struct packed {
        logic [1:0] cmd;
        t_data      a_re;
        t_data      a_im;
        t_data      b_re;
        t_data      b_im;
    } t_in;

    typedef struct packed {
        t_data res_re;
        t_data res_im;
        logic  div_zero;
        logic  overflow;
    } t_out;

    // queued transaction with its class already worked out
    typedef struct packed {
        t_in  data;
        logic dz;
    } t_item;

    typedef struct packed {
        logic  ovf;
        t_data val;
    } t_sat;

    function automatic t_sat sat_w(input t_wide v);
        t_sat r;
        logic [WIDE_W-DATA_W:0] top;
        top = v[WIDE_W-1:DATA_W-1];
        if (&top || ~|top) begin
            r.ovf = 1'b0;
            r.val = v[DATA_W-1:0];
        end else begin
            r.ovf = 1'b1;
            r.val = v[WIDE_W-1] ? SAT_MIN : SAT_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/cau_front.sv
`default_nettype none

module cau_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire cau_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output cau_pkg::t_item     o_item
);

    localparam int PTR_W = $clog2(cau_pkg::QDEPTH);
    localparam int CNT_W = $clog2(cau_pkg::QDEPTH + 1);

    cau_pkg::t_item r_mem [cau_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic push, pop;
    cau_pkg::t_item n_item;

    assign o_ready = (r_cnt != CNT_W'(cau_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    // divide by a zero divisor is flagged here, the back end only zeroes it
    always_comb begin
        n_item.data = i_data;
        n_item.dz   = (i_data.cmd == cau_pkg::CMD_DIV) &&
                      (i_data.b_re == '0) && (i_data.b_im == '0);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(cau_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(cau_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/cau_back.sv
`default_nettype none

module cau_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire cau_pkg::t_item i_item,
    output logic                o_valid,
    input  wire logic           i_ready,
    output cau_pkg::t_out       o_data
);

    localparam int DW  = cau_pkg::DATA_W;
    localparam int PW  = cau_pkg::PROD_W;
    localparam int FB  = cau_pkg::FRAC_BITS;
    localparam int NW  = PW + FB;
    localparam int R0W = NW - DW;

    typedef struct packed {
        logic          neg;
        logic          big;
        logic [PW-1:0] rem;
        logic [DW-1:0] low;
        logic [DW-1:0] q;
    } t_dpart;

    typedef struct packed {
        t_dpart        re;
        t_dpart        im;
        logic [PW-1:0] den;
    } t_dv;

    typedef struct packed {
        logic          is_div;
        logic          dz;
        cau_pkg::t_out res;
    } t_pass;

    logic adv;

    // stage 1: products and sums
    logic                   r1_vld;
    logic [1:0]             r1_cmd;
    logic                   r1_dz;
    logic signed [PW-1:0]   r1_rr, r1_ii, r1_ri, r1_ir, r1_bbr, r1_bbi;
    logic signed [DW:0]     r1_sre, r1_sim;

    // stage 2: combined terms
    logic                   r2_vld;
    t_pass                  r2_ps;
    cau_pkg::t_wide         r2_nre, r2_nim;
    logic [PW-1:0]          r2_den;
    t_pass                  n2_ps;

    // divider stages
    logic                   r_dvv [DW+1];
    t_dv                    r_dv  [DW+1];
    t_pass                  r_ps  [DW+1];
    t_dv                    n_dv0;

    logic                   r_out_valid;
    cau_pkg::t_out          r_out;
    cau_pkg::t_out          n_out;

    assign adv     = !r_out_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    function automatic t_dpart start_part(input cau_pkg::t_wide num, input logic [PW-1:0] den);
        t_dpart p;
        logic [PW:0]    mag;
        logic [NW-1:0]  nn;
        logic [R0W-1:0] r0;
        p.neg = num[PW];
        mag   = num[PW] ? (PW+1)'(-num) : (PW+1)'(num);
        nn    = NW'(mag[PW-1:0]) << FB;
        r0    = nn[NW-1:DW];
        p.big = (r0 >= den);
        p.rem = PW'(r0);
        p.low = nn[DW-1:0];
        p.q   = '0;
        return p;
    endfunction

    function automatic t_dpart step_part(input t_dpart x, input logic [PW-1:0] den);
        t_dpart p;
        logic [PW:0] r2;
        logic        bit_q;
        p     = x;
        r2    = {x.rem, x.low[DW-1]};
        bit_q = (r2 >= {1'b0, den});
        if (bit_q) begin
            r2 = r2 - {1'b0, den};
        end
        p.rem = r2[PW-1:0];
        p.low = x.low << 1;
        p.q   = {x.q[DW-2:0], bit_q};
        return p;
    endfunction

    function automatic cau_pkg::t_sat fin_part(input t_dpart p);
        cau_pkg::t_sat s;
        if (p.big) begin
            s.ovf = 1'b1;
            s.val = p.neg ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
        end else if (!p.neg) begin
            s.ovf = p.q[DW-1];
            s.val = p.q[DW-1] ? cau_pkg::SAT_MAX : cau_pkg::t_data'(p.q);
        end else begin
            // negative limit is one further out than the positive one
            s.ovf = p.q[DW-1] && (p.q[DW-2:0] != '0);
            s.val = s.ovf ? cau_pkg::SAT_MIN : cau_pkg::t_data'(-p.q);
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_cmd <= i_item.data.cmd;
            r1_dz  <= i_item.dz;
            r1_rr  <= i_item.data.a_re * i_item.data.b_re;
            r1_ii  <= i_item.data.a_im * i_item.data.b_im;
            r1_ri  <= i_item.data.a_re * i_item.data.b_im;
            r1_ir  <= i_item.data.a_im * i_item.data.b_re;
            r1_bbr <= i_item.data.b_re * i_item.data.b_re;
            r1_bbi <= i_item.data.b_im * i_item.data.b_im;
            if (i_item.data.cmd == cau_pkg::CMD_SUB) begin
                r1_sre <= (DW+1)'(i_item.data.a_re) - (DW+1)'(i_item.data.b_re);
                r1_sim <= (DW+1)'(i_item.data.a_im) - (DW+1)'(i_item.data.b_im);
            end else begin
                r1_sre <= (DW+1)'(i_item.data.a_re) + (DW+1)'(i_item.data.b_re);
                r1_sim <= (DW+1)'(i_item.data.a_im) + (DW+1)'(i_item.data.b_im);
            end
        end
    end

    always_comb begin
        cau_pkg::t_wide mre, mim;
        cau_pkg::t_sat  sre, sim;
        mre = cau_pkg::t_wide'(r1_rr) - cau_pkg::t_wide'(r1_ii);
        mim = cau_pkg::t_wide'(r1_ri) + cau_pkg::t_wide'(r1_ir);
        if (r1_cmd == cau_pkg::CMD_MUL) begin
            sre = cau_pkg::sat_w(mre >>> FB);
            sim = cau_pkg::sat_w(mim >>> FB);
        end else begin
            sre = cau_pkg::sat_w(cau_pkg::t_wide'(r1_sre));
            sim = cau_pkg::sat_w(cau_pkg::t_wide'(r1_sim));
        end
        n2_ps.is_div       = (r1_cmd == cau_pkg::CMD_DIV);
        n2_ps.dz           = r1_dz;
        n2_ps.res.res_re   = sre.val;
        n2_ps.res.res_im   = sim.val;
        n2_ps.res.div_zero = 1'b0;
        n2_ps.res.overflow = sre.ovf || sim.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_ps  <= n2_ps;
            r2_nre <= cau_pkg::t_wide'(r1_rr) + cau_pkg::t_wide'(r1_ii);
            r2_nim <= cau_pkg::t_wide'(r1_ir) - cau_pkg::t_wide'(r1_ri);
            r2_den <= PW'($unsigned(r1_bbr)) + PW'($unsigned(r1_bbi));
        end
    end

    always_comb begin
        n_dv0.re  = start_part(r2_nre, r2_den);
        n_dv0.im  = start_part(r2_nim, r2_den);
        n_dv0.den = r2_den;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv[0] <= n_dv0;
            r_ps[0] <= r2_ps;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= DW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv[k].re  <= step_part(r_dv[k-1].re, r_dv[k-1].den);
                r_dv[k].im  <= step_part(r_dv[k-1].im, r_dv[k-1].den);
                r_dv[k].den <= r_dv[k-1].den;
                r_ps[k]     <= r_ps[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[k] <= 1'b0;
            end else if (adv) begin
                r_dvv[k] <= r_dvv[k-1];
            end
        end
    end

    always_comb begin
        cau_pkg::t_sat fre, fim;
        fre = fin_part(r_dv[DW].re);
        fim = fin_part(r_dv[DW].im);
        if (!r_ps[DW].is_div) begin
            n_out = r_ps[DW].res;
        end else if (r_ps[DW].dz) begin
            n_out.res_re   = '0;
            n_out.res_im   = '0;
            n_out.div_zero = 1'b1;
            n_out.overflow = 1'b0;
        end else begin
            n_out.res_re   = fre.val;
            n_out.res_im   = fim.val;
            n_out.div_zero = 1'b0;
            n_out.overflow = fre.ovf || fim.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r_dvv[0]    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r1_vld      <= i_valid;
            r2_vld      <= r1_vld;
            r_dvv[0]    <= r2_vld;
            r_out_valid <= r_dvv[DW];
        end
    end

endmodule

`default_nettype wire

FILE: design/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide on signed Q8.8 parts with saturation.
// A four-entry input queue feeds a pipeline that takes one transaction per
// cycle while the output is not held: products, then combined terms, then a
// restoring divider that resolves one quotient bit per stage (DATA_W stages),
// then the output register. Every transaction, divide or not, passes through
// every stage and leaves in order. The pipeline holds as a whole while
// the output waits; the queue keeps accepting until it is full.
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire cau_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output cau_pkg::t_out      o_data
);

    logic           q_valid;
    logic           q_ready;
    cau_pkg::t_item q_item;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.div_zero |->
            o_data.res_re == '0 && o_data.res_im == '0 && !o_data.overflow)
        else $error("zero divisor result not clean");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    a_queue_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_valid && q_ready && q_item.dz |-> q_item.data.cmd == cau_pkg::CMD_DIV)
        else $error("zero divisor flag on a non-divide");

endmodule

`default_nettype wire
